/* rtl/core/lfu_cache_table_core_defines.svh */
// Assertion macros for the LFU cache table checker.
// No dependencies; included by files that carry concurrent assertions.
`ifndef LFU_CACHE_TABLE_CORE_DEFINES_SVH
`define LFU_CACHE_TABLE_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is held.
`define LFU_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define LFU_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/core/lfu_pkg.sv */
// Shared types and constants for the LFU cache table.
// No dependencies; imported by lfu_cache_table_core and its testbench.
package lfu_pkg;

    localparam int          LFU_MAX_ENTRIES = 16;
    localparam int          CAP_W           = 5;
    localparam logic [4:0]  CAP_RESET       = 5'd16;
    localparam logic [31:0] COUNT_MAX       = 32'hFFFF_FFFF;
    localparam logic [31:0] COUNT_FIRST     = 32'd1;
    localparam logic [31:0] VALUE_MISS      = 32'hFFFF_FFFF;
    localparam logic [31:0] VALUE_PUT       = 32'd0;

    // Operation codes
    localparam logic OP_GET = 1'b0;
    localparam logic OP_PUT = 1'b1;

    // One stored entry: key, value, use count, last-touch stamp
    typedef struct packed {
        logic [31:0] key;
        logic [31:0] value;
        logic [31:0] count;
        logic [63:0] stamp;
    } t_entry;

endpackage

/* rtl/core/lfu_cache_table_core.sv */
// LFU cache table: key-value store with least-frequently-used replacement.
// Depends on lfu_pkg (entry type, op codes, reset constants).
//
// Usage:
//   Input channel (i_in_valid/o_in_ready) transfers one get or put request:
//   operation, lookup key and write value. Output channel
//   (o_out_valid/i_out_ready) transfers one result per request: key_found and
//   read_value (stored value on get hit, all ones on get miss, zero on put).
//   Config channel (i_cfg_valid/o_cfg_ready) writes capacity_in_use; write it
//   only while no request is in flight.
// Timing:
//   A request scans the occupied entries, one entry per cycle through the
//   entry memory's single read port, into one shared key/priority compare
//   unit. The input reopens when the result is written to the output
//   register, so a new request is taken only once the last one is finished.
// Reset and stall:
//   Reset empties the table, zeroes the touch clock and sets capacity to 16.
//   The memory needs no clearing pass: only entries below the fill count are
//   ever used. If the output stays stalled, the finished request waits in its
//   write-back step and the table is not updated until the older result moves.
module lfu_cache_table_core
    import lfu_pkg::*;
#(
    parameter int MAX_ENTRIES = LFU_MAX_ENTRIES
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // config write
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [CAP_W-1:0]   i_cfg_capacity_in_use,
    // request
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic               i_operation,
    input  logic signed [31:0] i_lookup_key,
    input  logic signed [31:0] i_write_value,
    // result
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic               o_key_found,
    output logic signed [31:0] o_read_value
);

    localparam int OCC_W = $clog2(MAX_ENTRIES + 1);
    localparam int AW    = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CMP_W = (OCC_W > CAP_W) ? OCC_W : CAP_W;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_WB
    } t_state;

    t_state            r_state;
    logic [CAP_W-1:0]  r_cap;
    logic [OCC_W-1:0]  r_occ;
    logic [63:0]       r_clock;

    // latched request
    logic              r_op;
    logic [31:0]       r_key;
    logic [31:0]       r_val;

    // scan control
    logic [OCC_W-1:0]  r_idx;
    logic              r_pend;
    logic [AW-1:0]     r_cmp_idx;

    // scan results
    logic              r_hit;
    logic [AW-1:0]     r_hit_slot;
    logic [31:0]       r_hit_val;
    logic [31:0]       r_hit_cnt;
    logic              r_have_v;
    logic [AW-1:0]     r_v_slot;
    logic [31:0]       r_v_cnt;
    logic [63:0]       r_v_stamp;

    // result register
    logic              r_out_valid;
    logic              r_key_found;
    logic [31:0]       r_read_value;

    // entry memory
    t_entry            r_mem [MAX_ENTRIES];
    t_entry            r_rd_data;

    logic              issue;
    logic              key_eq;
    logic              better;
    logic              wb_go;
    logic [31:0]       cnt_inc;
    logic [CMP_W-1:0]  cap_ext;
    logic [CMP_W-1:0]  cap_eff;
    logic [CMP_W-1:0]  occ_ext;
    logic              mem_we;
    logic [AW-1:0]     mem_wa;
    t_entry            mem_wd;
    logic              n_found;
    logic [31:0]       n_read_value;
    logic              occ_inc;

    assign o_cfg_ready  = 1'b1;
    assign o_in_ready   = (r_state == ST_IDLE);
    assign o_out_valid  = r_out_valid;
    assign o_key_found  = r_key_found;
    assign o_read_value = r_read_value;

    // Shared compare unit: key match and (count, stamp) priority
    assign issue  = (r_state == ST_SCAN) && (r_idx < r_occ);
    assign key_eq = (r_rd_data.key == r_key);
    assign better = !r_have_v ||
                    ({r_rd_data.count, r_rd_data.stamp} < {r_v_cnt, r_v_stamp});

    assign wb_go   = (r_state == ST_WB) && (!r_out_valid || i_out_ready);
    assign cnt_inc = (r_hit_cnt == COUNT_MAX) ? r_hit_cnt : r_hit_cnt + 32'd1;

    // Clamp capacity to the table size
    assign cap_ext = CMP_W'(r_cap);
    assign occ_ext = CMP_W'(r_occ);
    assign cap_eff = (cap_ext > CMP_W'(MAX_ENTRIES)) ? CMP_W'(MAX_ENTRIES) : cap_ext;

    // Decide the write-back and the result
    always_comb begin
        mem_we       = 1'b0;
        mem_wa       = r_hit_slot;
        mem_wd       = '{key: r_key, value: r_val, count: COUNT_FIRST, stamp: r_clock};
        n_found      = r_hit;
        n_read_value = VALUE_PUT;
        occ_inc      = 1'b0;
        if (r_op == OP_GET) begin
            if (r_hit) begin
                mem_we       = 1'b1;
                mem_wd.value = r_hit_val;
                mem_wd.count = cnt_inc;
                n_read_value = r_hit_val;
            end else begin
                n_read_value = VALUE_MISS;
            end
        end else if (cap_eff != '0) begin
            mem_we = 1'b1;
            if (r_hit) begin
                mem_wd.count = cnt_inc;
            end else if (occ_ext >= cap_eff) begin
                mem_wa = r_v_slot;
            end else begin
                mem_wa  = r_occ[AW-1:0];
                occ_inc = 1'b1;
            end
        end
    end

    // Entry memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (wb_go && mem_we) begin
            r_mem[mem_wa] <= mem_wd;
        end
        r_rd_data <= r_mem[r_idx[AW-1:0]];
    end

    // Sequencer, table bookkeeping and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cap       <= CAP_RESET;
            r_occ       <= '0;
            r_clock     <= '0;
            r_pend      <= 1'b0;
            r_hit       <= 1'b0;
            r_have_v    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_cap <= i_cfg_capacity_in_use;
            end
            // drop the result once the receiver takes it
            if (r_out_valid && i_out_ready && !wb_go) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (i_in_valid) begin
                        r_op     <= i_operation;
                        r_key    <= i_lookup_key;
                        r_val    <= i_write_value;
                        r_idx    <= '0;
                        r_pend   <= 1'b0;
                        r_hit    <= 1'b0;
                        r_have_v <= 1'b0;
                        r_state  <= ST_SCAN;
                    end
                end
                ST_SCAN: begin
                    // advance the read address, compare the entry read last cycle
                    r_pend    <= issue;
                    r_cmp_idx <= r_idx[AW-1:0];
                    if (issue) begin
                        r_idx <= r_idx + OCC_W'(1);
                    end
                    if (r_pend) begin
                        if (!r_hit && key_eq) begin
                            r_hit      <= 1'b1;
                            r_hit_slot <= r_cmp_idx;
                            r_hit_val  <= r_rd_data.value;
                            r_hit_cnt  <= r_rd_data.count;
                        end
                        if (better) begin
                            r_have_v  <= 1'b1;
                            r_v_slot  <= r_cmp_idx;
                            r_v_cnt   <= r_rd_data.count;
                            r_v_stamp <= r_rd_data.stamp;
                        end
                    end
                    if (!issue && !r_pend) begin
                        r_state <= ST_WB;
                    end
                end
                ST_WB: begin
                    // hold until the result register is free
                    if (wb_go) begin
                        r_out_valid  <= 1'b1;
                        r_key_found  <= n_found;
                        r_read_value <= n_read_value;
                        if (mem_we) begin
                            r_clock <= r_clock + 64'd1;
                        end
                        if (occ_inc) begin
                            r_occ <= r_occ + OCC_W'(1);
                        end
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

endmodule

/* rtl/core/lfu_core_checker.sv */
// Port-level checker for lfu_cache_table_core, bound into every instance of it.
// Depends on lfu_cache_table_core_defines.svh for the assertion macros.
`include "lfu_cache_table_core_defines.svh"

module lfu_core_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_ready,
    input logic               o_out_valid,
    input logic               i_out_ready,
    input logic               o_key_found,
    input logic signed [31:0] o_read_value
);

    // One request at a time: a transfer closes the input for the next cycle
    `LFU_ASSERT_NEXT(a_busy_after_in, i_clk, i_rst_n,
        i_in_valid && o_in_ready, !o_in_ready, "input ready right after a transfer")

    // A stalled result holds its payload
    `LFU_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready,
        o_out_valid && $stable(o_read_value) && $stable(o_key_found), "stalled result changed")

    // A miss reads all ones (get) or zero (put)
    `LFU_ASSERT_NOW(a_miss_value, i_clk, i_rst_n, o_out_valid && !o_key_found,
        (o_read_value == 32'hFFFF_FFFF) || (o_read_value == 32'd0), "bad value on a miss")

    // A result never appears right behind its request transfer
    `LFU_ASSERT_NOW(a_min_latency, i_clk, i_rst_n, $rose(o_out_valid),
        !$past(i_in_valid && o_in_ready), "result too early")

endmodule

bind lfu_cache_table_core lfu_core_checker u_lfu_core_checker (.*);

/* tb/sv/tb_lfu_cache_table_core.sv */
// Self-checking testbench for lfu_cache_table_core: directed plan, then random get/put traffic.
// Depends on lfu_pkg and lfu_cache_table_core; results are checked against an in-bench LFU model.
module tb_lfu_cache_table_core;
    timeunit 1ns;
    timeprecision 1ps;

    import lfu_pkg::*;

    localparam int QUIET_LIMIT = 4000;
    localparam int NUM_PHASES  = 12;
    localparam int PHASE_ITEMS = 120;

    typedef enum logic {ROW_ITEM, ROW_CFG} t_row_kind;

    // One directed step: a request, or a capacity write
    typedef struct packed {
        t_row_kind   kind;
        logic        op;
        logic [31:0] key;
        logic [31:0] val;
        logic [4:0]  cap;
        logic        typed;
        logic        found;
        logic [31:0] rd;
    } t_plan_row;

    typedef struct {
        logic        found;
        logic [31:0] value;
    } t_lookup_result;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_cfg_valid;
    logic               o_cfg_ready;
    logic [CAP_W-1:0]   i_cfg_capacity_in_use;
    logic               i_in_valid;
    logic               o_in_ready;
    logic               i_operation;
    logic signed [31:0] i_lookup_key;
    logic signed [31:0] i_write_value;
    logic               o_out_valid;
    logic               i_out_ready;
    logic               o_key_found;
    logic signed [31:0] o_read_value;

    // Model of the table
    t_entry      lfu_entry [LFU_MAX_ENTRIES];
    logic        lfu_valid [LFU_MAX_ENTRIES];
    logic [63:0] lfu_touch_clock;
    logic [4:0]  lfu_fill;
    logic [4:0]  lfu_capacity;

    t_lookup_result awaited_lookups[$];
    logic [31:0]    key_pool[$];
    int             error_count = 0;
    int             quiet_cycles = 0;
    int unsigned    idle_pct;
    int unsigned    stall_pct;

    int unsigned phase_cap [NUM_PHASES] = '{16, 4, 1, 0, 31, 8, 2, 16, 20, 5, 16, 12};

    t_plan_row directed_plan [24] = '{
        '{ROW_ITEM, OP_GET, 32'h0000_0000, 32'h0000_0000, 5'd0, 1'b1, 1'b0, VALUE_MISS},
        '{ROW_ITEM, OP_PUT, 32'h7FFF_FFFF, 32'h8000_0000, 5'd0, 1'b1, 1'b0, VALUE_PUT},
        '{ROW_ITEM, OP_PUT, 32'h8000_0000, 32'h7FFF_FFFF, 5'd0, 1'b1, 1'b0, VALUE_PUT},
        '{ROW_ITEM, OP_PUT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 5'd0, 1'b1, 1'b0, VALUE_PUT},
        '{ROW_ITEM, OP_PUT, 32'h0000_0000, 32'h0000_0000, 5'd0, 1'b1, 1'b0, VALUE_PUT},
        '{ROW_ITEM, OP_GET, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 5'd0, 1'b1, 1'b1, 32'h8000_0000},
        '{ROW_ITEM, OP_PUT, 32'hFFFF_FFFF, 32'h1234_5678, 5'd0, 1'b1, 1'b1, VALUE_PUT},
        '{ROW_ITEM, OP_GET, 32'hFFFF_FFFF, 32'h0000_0000, 5'd0, 1'b1, 1'b1, 32'h1234_5678},
        // lower capacity below the fill count: next insert evicts on a count tie
        '{ROW_CFG,  OP_GET, 32'h0000_0000, 32'h0000_0000, 5'd2, 1'b0, 1'b0, 32'h0},
        '{ROW_ITEM, OP_PUT, 32'h0000_0001, 32'h0000_0001, 5'd0, 1'b0, 1'b0, 32'h0},
        '{ROW_ITEM, OP_GET, 32'h8000_0000, 32'h0000_0000, 5'd0, 1'b0, 1'b0, 32'h0},
        '{ROW_ITEM, OP_GET, 32'h0000_0000, 32'h0000_0000, 5'd0, 1'b0, 1'b0, 32'h0},
        // capacity zero: puts change nothing, presence is still reported
        '{ROW_CFG,  OP_GET, 32'h0000_0000, 32'h0000_0000, 5'd0, 1'b0, 1'b0, 32'h0},
        '{ROW_ITEM, OP_PUT, 32'h5555_AAAA, 32'h0000_0001, 5'd0, 1'b1, 1'b0, VALUE_PUT},
        '{ROW_ITEM, OP_GET, 32'h5555_AAAA, 32'h0000_0000, 5'd0, 1'b1, 1'b0, VALUE_MISS},
        '{ROW_ITEM, OP_PUT, 32'h7FFF_FFFF, 32'h0000_0000, 5'd0, 1'b1, 1'b1, VALUE_PUT},
        '{ROW_ITEM, OP_GET, 32'h7FFF_FFFF, 32'h0000_0000, 5'd0, 1'b1, 1'b1, 32'h8000_0000},
        // capacity above the table size is clamped to the table size
        '{ROW_CFG,  OP_GET, 32'h0000_0000, 32'h0000_0000, 5'd31, 1'b0, 1'b0, 32'h0},
        '{ROW_ITEM, OP_PUT, 32'hAAAA_5555, 32'h5555_5555, 5'd0, 1'b0, 1'b0, 32'h0},
        '{ROW_ITEM, OP_GET, 32'hAAAA_5555, 32'h0000_0000, 5'd0, 1'b0, 1'b0, 32'h0},
        '{ROW_CFG,  OP_GET, 32'h0000_0000, 32'h0000_0000, 5'd1, 1'b0, 1'b0, 32'h0},
        '{ROW_ITEM, OP_PUT, 32'h0000_FFFF, 32'hFFFF_0000, 5'd0, 1'b0, 1'b0, 32'h0},
        '{ROW_ITEM, OP_GET, 32'h0000_FFFF, 32'h0000_0000, 5'd0, 1'b0, 1'b0, 32'h0},
        '{ROW_ITEM, OP_GET, 32'h7FFF_FFFF, 32'h0000_0000, 5'd0, 1'b0, 1'b0, 32'h0}
    };

    lfu_cache_table_core DUT (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .i_cfg_valid           (i_cfg_valid),
        .o_cfg_ready           (o_cfg_ready),
        .i_cfg_capacity_in_use (i_cfg_capacity_in_use),
        .i_in_valid            (i_in_valid),
        .o_in_ready            (o_in_ready),
        .i_operation           (i_operation),
        .i_lookup_key          (i_lookup_key),
        .i_write_value         (i_write_value),
        .o_out_valid           (o_out_valid),
        .i_out_ready           (i_out_ready),
        .o_key_found           (o_key_found),
        .o_read_value          (o_read_value)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Raise the use count (saturating) and stamp the entry
    function automatic void lfu_touch_hit(input int slot);
        if (lfu_entry[slot].count != COUNT_MAX) lfu_entry[slot].count += 32'd1;
        lfu_entry[slot].stamp = lfu_touch_clock;
        lfu_touch_clock += 64'd1;
    endfunction

    // Apply one get or put to the model and return its result
    function automatic t_lookup_result lfu_lookup_update(input logic op,
                                                         input logic [31:0] key,
                                                         input logic [31:0] val);
        t_lookup_result res;
        int hit_slot;
        int free_slot;
        int victim;
        int slot;
        int eff_cap;
        hit_slot  = -1;
        free_slot = -1;
        victim    = -1;
        eff_cap   = (int'(lfu_capacity) > LFU_MAX_ENTRIES) ? LFU_MAX_ENTRIES
                                                           : int'(lfu_capacity);

        // scan: first matching key, lowest count with oldest stamp, first free slot
        for (int i = 0; i < LFU_MAX_ENTRIES; i++) begin
            if (lfu_valid[i]) begin
                if (hit_slot < 0 && lfu_entry[i].key == key) hit_slot = i;
                if (victim < 0 || lfu_entry[i].count < lfu_entry[victim].count ||
                    (lfu_entry[i].count == lfu_entry[victim].count &&
                     lfu_entry[i].stamp < lfu_entry[victim].stamp)) victim = i;
            end else if (free_slot < 0) begin
                free_slot = i;
            end
        end

        res.found = (hit_slot >= 0);
        if (op == OP_GET) begin
            res.value = VALUE_MISS;
            if (res.found) begin
                res.value = lfu_entry[hit_slot].value;
                lfu_touch_hit(hit_slot);
            end
            return res;
        end

        res.value = VALUE_PUT;
        if (eff_cap == 0) return res;
        if (res.found) begin
            lfu_entry[hit_slot].value = val;
            lfu_touch_hit(hit_slot);
            return res;
        end

        // insert: evict when at capacity, else take the first free slot
        if (int'(lfu_fill) >= eff_cap && victim >= 0) begin
            slot = victim;
        end else if (free_slot >= 0) begin
            slot = free_slot;
        end else if (victim >= 0) begin
            slot = victim;
        end else begin
            return res;
        end
        if (lfu_valid[slot]) lfu_fill -= 5'd1;
        lfu_valid[slot]       = 1'b1;
        lfu_entry[slot].key   = key;
        lfu_entry[slot].value = val;
        lfu_entry[slot].count = COUNT_FIRST;
        lfu_entry[slot].stamp = lfu_touch_clock;
        lfu_touch_clock += 64'd1;
        lfu_fill += 5'd1;
        return res;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("[%0t] mismatch on %s: got 0x%08h, want 0x%08h", $time, what, got, want);
        error_count++;
    endtask

    // Hold valid and payload until the transfer, then record the expected result
    task automatic send_request(input logic op, input logic [31:0] key, input logic [31:0] val,
                                input logic typed, input logic want_found,
                                input logic [31:0] want_value);
        t_lookup_result res;
        while ($urandom_range(99) < idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_operation   <= op;
        i_lookup_key  <= key;
        i_write_value <= val;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        res = lfu_lookup_update(op, key, val);
        if (typed) begin
            res.found = want_found;
            res.value = want_value;
        end
        awaited_lookups.push_back(res);
    endtask

    // Drop valid and wait until every outstanding result has come back
    task automatic drain_results();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (awaited_lookups.size() != 0) @(posedge i_clk);
    endtask

    // Write the capacity register while the table is idle
    task automatic write_capacity(input logic [4:0] cap);
        drain_results();
        repeat (4) @(posedge i_clk);
        i_cfg_valid           <= 1'b1;
        i_cfg_capacity_in_use <= cap;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        lfu_capacity = cap;
        i_cfg_valid <= 1'b0;
    endtask

    // Result side: check each transfer, then stall at random
    initial begin
        t_lookup_result want;
        i_out_ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid && i_out_ready) begin
                if (awaited_lookups.size() == 0) begin
                    report_mismatch("unexpected result", o_read_value, 32'h0);
                end else begin
                    want = awaited_lookups.pop_front();
                    if (o_key_found !== want.found)
                        report_mismatch("key_found", 32'(o_key_found), 32'(want.found));
                    if (o_read_value !== want.value)
                        report_mismatch("read_value", o_read_value, want.value);
                end
            end
            i_out_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // Count cycles with no transfer on any channel
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) ||
            (i_cfg_valid && o_cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial begin
        while (quiet_cycles < QUIET_LIMIT) @(posedge i_clk);
        $display("tb_lfu_cache_table_core: FAIL");
        $finish;
    end

    initial begin
        int unsigned pool_size;
        int unsigned eff_cap;
        logic [31:0] key;
        i_rst_n               <= 1'b0;
        i_in_valid            <= 1'b0;
        i_operation           <= OP_GET;
        i_lookup_key          <= '0;
        i_write_value         <= '0;
        i_cfg_valid           <= 1'b0;
        i_cfg_capacity_in_use <= CAP_RESET;
        idle_pct  = 0;
        stall_pct = 0;
        for (int i = 0; i < LFU_MAX_ENTRIES; i++) begin
            lfu_valid[i] = 1'b0;
            lfu_entry[i] = '0;
        end
        lfu_touch_clock = '0;
        lfu_fill        = '0;
        lfu_capacity    = CAP_RESET;

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Walk the directed plan
        foreach (directed_plan[r]) begin
            if (directed_plan[r].kind == ROW_CFG)
                write_capacity(directed_plan[r].cap);
            else
                send_request(directed_plan[r].op, directed_plan[r].key, directed_plan[r].val,
                             directed_plan[r].typed, directed_plan[r].found,
                             directed_plan[r].rd);
        end

        // Random phases: new capacity, new key pool, new idling mix
        for (int p = 0; p < NUM_PHASES; p++) begin
            write_capacity(phase_cap[p][4:0]);
            case (p % 4)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 65; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 65; end
                default: begin idle_pct = 8; stall_pct = 8; end
            endcase
            eff_cap   = (phase_cap[p] > LFU_MAX_ENTRIES) ? LFU_MAX_ENTRIES : phase_cap[p];
            pool_size = eff_cap + 3;
            key_pool.delete();
            for (int k = 0; k < pool_size; k++) key_pool.push_back($urandom);

            for (int n = 0; n < PHASE_ITEMS; n++) begin
                // occasionally hold off until the pipeline is empty
                if ($urandom_range(63) == 0) drain_results();
                if ($urandom_range(99) < 85)
                    key = key_pool[$urandom_range(pool_size - 1)];
                else
                    key = $urandom;
                send_request($urandom_range(1) ? OP_PUT : OP_GET, key, $urandom,
                             1'b0, 1'b0, 32'h0);
            end
        end

        drain_results();
        idle_pct  = 0;
        stall_pct = 0;
        repeat (40) @(posedge i_clk);
        if (error_count == 0 && awaited_lookups.size() == 0)
            $display("tb_lfu_cache_table_core: PASS");
        else
            $display("tb_lfu_cache_table_core: FAIL");
        $finish;
    end

endmodule
